>>> hdl/edhq_pkg.sv
// ----------------------------------------------------------------------------
// Earliest-deadline heap queue package
// Shared codes, controller states, capacity field width and reset capacity.
// ----------------------------------------------------------------------------
package edhq_pkg;

   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STAT_INSERTED = 2'd0,
      STAT_REMOVED  = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_ROOT,
      ST_POP_LAST,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_DONE
   } state_type;

endpackage

>>> hdl/edhq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read, no reset.
// ----------------------------------------------------------------------------
module edhq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/earliest_deadline_heap_queue.sv
// ----------------------------------------------------------------------------
// Earliest-deadline heap queue
// Task queue kept as a binary min-heap in one RAM, ordered by deadline and
// then by task id.
//
// A request word either inserts a task (id and deadline) or removes the task
// with the least deadline. Each request word yields exactly one response word
// with a status, the removed task (zero unless removed) and the occupancy
// after the request. The csr channel writes the capacity limit; inserts are
// rejected while the occupancy has reached it or the queue depth.
// One request is worked on at a time; req_stall is high while it is in
// flight. The heap lives in a RAM with one read and one write port and a
// registered read. A sift-up step reads the parent and compares in the next
// cycle; a sift-down step reads both children and then compares.
// An insert takes longer for each level climbed and a remove for each level
// descended; removing the last task and rejected requests skip the heap
// walk. The response word appears in the same cycle as the next request can
// be taken and sits in an output register; while rsp_stall is high it holds,
// and a finished request waits in the done state until the register frees.
// Reset empties the queue and sets the capacity limit to 16; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module earliest_deadline_heap_queue #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int ID_BITS       = 8,
   parameter int DEADLINE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [ID_BITS-1:0]                   req_task_id,
   input  logic [DEADLINE_BITS-1:0]             req_deadline,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [ID_BITS-1:0]                   rsp_out_task_id,
   output logic [DEADLINE_BITS-1:0]             rsp_out_deadline,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]     rsp_occupancy,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [edhq_pkg::CAP_W-1:0]           csr_capacity_limit
);

   import edhq_pkg::*;

   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int ENT_W  = ID_BITS + DEADLINE_BITS;
   localparam int CW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int CH_W   = ADDR_W + 2;

   function automatic logic earlier(input logic [ENT_W-1:0] a, input logic [ENT_W-1:0] b);
      logic [DEADLINE_BITS-1:0] a_dl;
      logic [DEADLINE_BITS-1:0] b_dl;
      logic [ID_BITS-1:0]       a_id;
      logic [ID_BITS-1:0]       b_id;
      a_dl = a[DEADLINE_BITS-1:0];
      b_dl = b[DEADLINE_BITS-1:0];
      a_id = a[ENT_W-1:DEADLINE_BITS];
      b_id = b[ENT_W-1:DEADLINE_BITS];
      if (a_dl != b_dl) begin
         return a_dl < b_dl;
      end
      return a_id < b_id;
   endfunction

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CAP_W-1:0]         cap_ff, cap_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic [ENT_W-1:0]         carry_ff, carry_in;
   logic [ENT_W-1:0]         lchild_ff, lchild_in;
   logic                     rvalid_ff, rvalid_in;
   status_type               res_status_ff, res_status_in;
   logic [ENT_W-1:0]         res_entry_ff, res_entry_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [ENT_W-1:0]         rsp_entry_ff, rsp_entry_in;
   logic [CNT_W-1:0]         rsp_occ_ff, rsp_occ_in;

   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [ENT_W-1:0]         ram_wr_data;
   logic                     ram_rd_en;
   logic [ADDR_W-1:0]        ram_rd_addr;
   logic [ENT_W-1:0]         ram_rd_data;

   logic                     req_accept;
   logic                     heap_full;
   logic [ADDR_W-1:0]        parent_addr;
   logic [CH_W-1:0]          left_idx;
   logic [CH_W-1:0]          right_idx;
   logic [CH_W-1:0]          count_wide;
   logic                     take_left;
   logic                     take_right;
   logic [ENT_W-1:0]         cand;

   edhq_ram #(
      .WIDTH(ENT_W),
      .DEPTH(QUEUE_DEPTH)
   ) heap_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign heap_full   = (CW'(count_ff) >= CW'(cap_ff)) || (count_ff >= CNT_W'(QUEUE_DEPTH));
   assign parent_addr = ADDR_W'((pos_ff - 1'b1) >> 1);
   assign left_idx    = CH_W'({pos_ff, 1'b1});
   assign right_idx   = left_idx + 1'b1;
   assign count_wide  = CH_W'(count_ff);

   assign take_left  = earlier(lchild_ff, carry_ff);
   assign cand       = take_left ? lchild_ff : carry_ff;
   assign take_right = rvalid_ff && earlier(ram_rd_data, cand);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      pos_in        = pos_ff;
      carry_in      = carry_ff;
      lchild_in     = lchild_ff;
      rvalid_in     = rvalid_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pos_ff;
      ram_wr_data   = carry_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      if (csr_valid && csr_ready) begin
         cap_in = csr_capacity_limit;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               res_entry_in = '0;
               if (req_op == OP_INSERT) begin
                  if (heap_full) begin
                     res_status_in = STAT_FULL;
                     state_in      = ST_DONE;
                  end else begin
                     res_status_in = STAT_INSERTED;
                     carry_in      = {req_task_id, req_deadline};
                     pos_in        = count_ff[ADDR_W-1:0];
                     count_in      = CNT_W'(count_ff + 1'b1);
                     state_in      = ST_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = STAT_EMPTY;
                     state_in      = ST_DONE;
                  end else begin
                     res_status_in = STAT_REMOVED;
                     count_in      = CNT_W'(count_ff - 1'b1);
                     ram_rd_en     = 1'b1;
                     ram_rd_addr   = '0;
                     state_in      = ST_POP_ROOT;
                  end
               end
            end
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               ram_wr_en = 1'b1;
               state_in  = ST_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = parent_addr;
               state_in    = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            ram_wr_en = 1'b1;
            if (earlier(carry_ff, ram_rd_data)) begin
               ram_wr_data = ram_rd_data;
               pos_in      = parent_addr;
               state_in    = ST_UP_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_POP_ROOT: begin
            res_entry_in = ram_rd_data;
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = count_ff[ADDR_W-1:0];
               state_in    = ST_POP_LAST;
            end
         end
         ST_POP_LAST: begin
            carry_in = ram_rd_data;
            pos_in   = '0;
            state_in = ST_DN_RDL;
         end
         ST_DN_RDL: begin
            if (left_idx >= count_wide) begin
               ram_wr_en = 1'b1;
               state_in  = ST_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = left_idx[ADDR_W-1:0];
               state_in    = ST_DN_RDR;
            end
         end
         ST_DN_RDR: begin
            lchild_in = ram_rd_data;
            rvalid_in = right_idx < count_wide;
            if (right_idx < count_wide) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = right_idx[ADDR_W-1:0];
            end
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            ram_wr_en = 1'b1;
            if (take_right) begin
               ram_wr_data = ram_rd_data;
               pos_in      = right_idx[ADDR_W-1:0];
               state_in    = ST_DN_RDL;
            end else if (take_left) begin
               ram_wr_data = lchild_ff;
               pos_in      = left_idx[ADDR_W-1:0];
               state_in    = ST_DN_RDL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_occ_in    = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      carry_ff      <= carry_in;
      lchild_ff     <= lchild_in;
      rvalid_ff     <= rvalid_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_task_id  = rsp_entry_ff[ENT_W-1:DEADLINE_BITS];
   assign rsp_out_deadline = rsp_entry_ff[DEADLINE_BITS-1:0];
   assign rsp_occupancy    = rsp_occ_ff;

endmodule

>>> bench/edhq_checker.sv
// ----------------------------------------------------------------------------
// Earliest-deadline heap queue checker
// Watches the request, response and csr channels of the queue. It keeps its
// own min-heap of held tasks and works out the response word for each
// accepted request. Each accepted response word is compared field by field
// with the oldest expected word. The mismatch count and the number of words
// still awaited are handed to the testbench top.
// ----------------------------------------------------------------------------
module edhq_checker #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int ID_BITS       = 8,
   parameter int DEADLINE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [ID_BITS-1:0]                   req_task_id,
   input  logic [DEADLINE_BITS-1:0]             req_deadline,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [1:0]                           rsp_status,
   input  logic [ID_BITS-1:0]                   rsp_out_task_id,
   input  logic [DEADLINE_BITS-1:0]             rsp_out_deadline,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     rsp_occupancy,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [edhq_pkg::CAP_W-1:0]           csr_capacity_limit,
   output int                                   mismatch_count,
   output int                                   pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   import edhq_pkg::*;

   localparam int OCC_W = $clog2(QUEUE_DEPTH+1);

   typedef struct packed {
      status_type                 status;
      logic [ID_BITS-1:0]         task_id;
      logic [DEADLINE_BITS-1:0]   deadline;
      logic [OCC_W-1:0]           occupancy;
   } queue_word_type;

   logic [ID_BITS-1:0]       heap_id [QUEUE_DEPTH];
   logic [DEADLINE_BITS-1:0] heap_dl [QUEUE_DEPTH];
   int                       held_count;
   logic [CAP_W-1:0]         capacity;
   queue_word_type           expected_words [$];

   initial mismatch_count = 0;
   initial pending_words = 0;

   function automatic bit leaves_first(int a, int b);
      if (heap_dl[a] != heap_dl[b]) return heap_dl[a] < heap_dl[b];
      return heap_id[a] < heap_id[b];
   endfunction

   function automatic void swap_entries(int a, int b);
      logic [ID_BITS-1:0]       t_id;
      logic [DEADLINE_BITS-1:0] t_dl;
      t_id = heap_id[a];
      t_dl = heap_dl[a];
      heap_id[a] = heap_id[b];
      heap_dl[a] = heap_dl[b];
      heap_id[b] = t_id;
      heap_dl[b] = t_dl;
   endfunction

   function automatic queue_word_type serve_request(logic op, logic [ID_BITS-1:0] id,
                                                    logic [DEADLINE_BITS-1:0] dl);
      queue_word_type w;
      int             limit;
      int             pos;
      int             left;
      int             best;
      bit             moving;
      w = '0;
      limit = (capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(capacity);
      if (op == OP_INSERT) begin
         if (held_count >= limit) begin
            w.status = STAT_FULL;
         end else begin
            pos = held_count;
            heap_id[pos] = id;
            heap_dl[pos] = dl;
            held_count++;
            while (pos > 0 && leaves_first(pos, (pos - 1) / 2)) begin
               swap_entries(pos, (pos - 1) / 2);
               pos = (pos - 1) / 2;
            end
            w.status = STAT_INSERTED;
         end
      end else if (held_count == 0) begin
         w.status = STAT_EMPTY;
      end else begin
         w.status = STAT_REMOVED;
         w.task_id = heap_id[0];
         w.deadline = heap_dl[0];
         held_count--;
         heap_id[0] = heap_id[held_count];
         heap_dl[0] = heap_dl[held_count];
         pos = 0;
         moving = 1'b1;
         while (moving) begin
            left = 2 * pos + 1;
            best = pos;
            if (left < held_count && leaves_first(left, best)) best = left;
            if (left + 1 < held_count && leaves_first(left + 1, best)) best = left + 1;
            if (best == pos) begin
               moving = 1'b0;
            end else begin
               swap_entries(pos, best);
               pos = best;
            end
         end
      end
      w.occupancy = OCC_W'(held_count);
      return w;
   endfunction

   task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t edhq_checker: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      queue_word_type want;
      if (reset) begin
         held_count = 0;
         capacity = CAP_RESET;
         expected_words.delete();
         pending_words <= 0;
      end else begin
         if (csr_valid && csr_ready) capacity = csr_capacity_limit;
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               mismatch_count++;
               $display("%0t edhq_checker: expected no word, got status %0d task %0d",
                        $time, rsp_status, rsp_out_task_id);
               $display("%0t edhq_checker: unexpected word has deadline %0d",
                        $time, rsp_out_deadline);
            end else begin
               want = expected_words.pop_front();
               flag_field("status", want.status, rsp_status);
               flag_field("task id", want.task_id, rsp_out_task_id);
               flag_field("deadline", want.deadline, rsp_out_deadline);
               flag_field("occupancy", want.occupancy, rsp_occupancy);
            end
         end
         if (req_valid && !req_stall) begin
            expected_words.push_back(serve_request(req_op, req_task_id, req_deadline));
         end
         pending_words <= expected_words.size();
      end
   end

endmodule

>>> bench/tb_earliest_deadline_heap_queue.sv
// ----------------------------------------------------------------------------
// Earliest-deadline heap queue testbench
// Drives request words into the queue: a directed fill with extreme and tied
// deadlines, then phases of random insert and remove bursts under several
// capacity limits, idle and response-stall patterns. A checker beside the
// block predicts every response word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_earliest_deadline_heap_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import edhq_pkg::*;

   localparam int QUEUE_DEPTH   = 16;
   localparam int ID_BITS       = 8;
   localparam int DEADLINE_BITS = 16;
   localparam int OCC_W         = $clog2(QUEUE_DEPTH+1);
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_WORDS   = 160;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_op = OP_INSERT;
   logic [ID_BITS-1:0]         req_task_id = '0;
   logic [DEADLINE_BITS-1:0]   req_deadline = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [1:0]                 rsp_status;
   logic [ID_BITS-1:0]         rsp_out_task_id;
   logic [DEADLINE_BITS-1:0]   rsp_out_deadline;
   logic [OCC_W-1:0]           rsp_occupancy;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CAP_W-1:0]           csr_capacity_limit = CAP_RESET;

   int mismatch_count;
   int pending_words;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   bit hold_go = 1'b0;

   logic [23:0] seed_tasks [16] = '{
      {8'hFF, 16'hFFFF}, {8'h00, 16'h0000}, {8'hAA, 16'h5555}, {8'h55, 16'hAAAA},
      {8'h09, 16'd100},  {8'h03, 16'd100},  {8'h03, 16'd100},  {8'h80, 16'h8000},
      {8'h7F, 16'h7FFF}, {8'h01, 16'hFFFF}, {8'hFE, 16'h0000}, {8'h10, 16'd200},
      {8'h11, 16'd50},   {8'h12, 16'd150},  {8'h13, 16'd100},  {8'h14, 16'd300}
   };
   logic [CAP_W-1:0] phase_caps [8] = '{
      5'd31, 5'd0, 5'd1, 5'd16, 5'd17, 5'd7, 5'd2, 5'd12
   };

   earliest_deadline_heap_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ID_BITS(ID_BITS),
      .DEADLINE_BITS(DEADLINE_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_task_id(req_task_id),
      .req_deadline(req_deadline),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_task_id(rsp_out_task_id),
      .rsp_out_deadline(rsp_out_deadline),
      .rsp_occupancy(rsp_occupancy),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_capacity_limit(csr_capacity_limit)
   );

   edhq_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ID_BITS(ID_BITS),
      .DEADLINE_BITS(DEADLINE_BITS)
   ) checker_0 (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_task_id(req_task_id),
      .req_deadline(req_deadline),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_task_id(rsp_out_task_id),
      .rsp_out_deadline(rsp_out_deadline),
      .rsp_occupancy(rsp_occupancy),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_capacity_limit(csr_capacity_limit),
      .mismatch_count(mismatch_count),
      .pending_words(pending_words)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (hold_go) begin
            hold_go = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb_earliest_deadline_heap_queue: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer_request(logic op, logic [ID_BITS-1:0] id,
                                logic [DEADLINE_BITS-1:0] dl);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_task_id <= id;
      req_deadline <= dl;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
      @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      drain_results();
      repeat (4) @(posedge clock);
      csr_capacity_limit <= value;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(int phase);
      logic                     op;
      logic [ID_BITS-1:0]       id;
      logic [DEADLINE_BITS-1:0] dl;
      int                       insert_pct;
      for (int i = 0; i < PHASE_WORDS; i++) begin
         if (phase == 4 && i == 40) hold_go = 1'b1;
         if (phase == 5 && i == 80) drain_results();
         insert_pct = ((i / 24) % 2 == 0) ? 80 : 25;
         op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
         id = ID_BITS'($urandom);
         case ($urandom_range(9))
            0: dl = DEADLINE_BITS'($urandom_range(7));
            1: dl = $urandom_range(1) ? '1 : '0;
            default: dl = DEADLINE_BITS'($urandom);
         endcase
         offer_request(op, id, dl);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_request(OP_REMOVE, 8'h00, 16'h0000);
      foreach (seed_tasks[i]) offer_request(OP_INSERT, seed_tasks[i][23:16], seed_tasks[i][15:0]);
      offer_request(OP_INSERT, 8'h20, 16'h0001);
      repeat (4) offer_request(OP_REMOVE, 8'hFF, 16'hFFFF);
      write_capacity(5'd4);
      offer_request(OP_INSERT, 8'h21, 16'h0002);
      offer_request(OP_REMOVE, 8'h00, 16'h0000);

      for (int p = 0; p < 8; p++) begin
         write_capacity(phase_caps[p]);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 88;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 88;
            end
            default: begin
               send_idle_pct = 14;
               stall_pct = 14;
            end
         endcase
         run_phase(p);
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_earliest_deadline_heap_queue: done, clean");
      end else begin
         $display("tb_earliest_deadline_heap_queue: done, errors");
      end
      $finish;
   end

endmodule
